FILE: rtl/hns_pkg.sv
// shared types and constants for the hamming nearest search
package hns_pkg;

  localparam int unsigned NumWords  = 8;
  localparam int unsigned WordW     = 64;
  localparam int unsigned WordSelW  = 3;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned LaneCntW  = 7;
  localparam int unsigned DistW     = 10;
  localparam int unsigned IdxW      = 16;

  localparam logic [DistW-1:0] MinReset = 10'd1023;
  localparam logic [DistW-1:0] MaxDist  = 10'd512;

  typedef logic [LaneCntW-1:0] lane_cnt_t;
  typedef logic [WordW-1:0]    word_t;

  // update stage control from the top level
  typedef struct packed {
    logic upd;   // item leaves the merge register this cycle
    logic last;  // that item ends the search
  } trk_ctl_t;

endpackage

FILE: rtl/hns_if.sv
// valid/ready channel interfaces for corpus vectors and search results
interface hns_in_if import hns_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t vec_word_0;
  word_t vec_word_1;
  word_t vec_word_2;
  word_t vec_word_3;
  word_t vec_word_4;
  word_t vec_word_5;
  word_t vec_word_6;
  word_t vec_word_7;
  logic  final_vector;

  modport source (
    output valid, vec_word_0, vec_word_1, vec_word_2, vec_word_3,
           vec_word_4, vec_word_5, vec_word_6, vec_word_7, final_vector,
    input  ready
  );
  modport sink (
    input  valid, vec_word_0, vec_word_1, vec_word_2, vec_word_3,
           vec_word_4, vec_word_5, vec_word_6, vec_word_7, final_vector,
    output ready
  );
endinterface

interface hns_out_if import hns_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IdxW-1:0]  best_index;
  logic [DistW-1:0] best_distance;

  modport source (output valid, best_index, best_distance, input ready);
  modport sink   (input valid, best_index, best_distance, output ready);
endinterface

FILE: rtl/hns_lane.sv
// one lane: xor of a 64-bit vector word with its query word, then popcount
module hns_lane import hns_pkg::*; (
  input  logic      clk_i,
  input  logic      load_i,
  input  word_t     vec_i,
  input  word_t     query_i,
  output lane_cnt_t cnt_o
);

  lane_cnt_t cnt_d, cnt_q;

  function automatic lane_cnt_t popcount64(input word_t x);
    word_t     a;
    word_t     b;
    word_t     c;
    lane_cnt_t acc;
    a = x - ((x >> 1) & 64'h5555_5555_5555_5555);
    b = (a & 64'h3333_3333_3333_3333) + ((a >> 2) & 64'h3333_3333_3333_3333);
    c = (b + (b >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
    acc = '0;
    // byte counts are at most 8
    for (int k = 0; k < 8; k++) begin
      acc = acc + LaneCntW'(c[8*k +: 8]);
    end
    return acc;
  endfunction

  assign cnt_d = popcount64(vec_i ^ query_i);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cnt_q <= cnt_d;
    end
  end

  assign cnt_o = cnt_q;

endmodule

FILE: rtl/hns_merge.sv
// merge stage: sums the lane counts into the full 512-bit distance
module hns_merge import hns_pkg::*; (
  input  logic             clk_i,
  input  logic             load_i,
  input  lane_cnt_t        cnt_i [NumWords],
  output logic [DistW-1:0] dist_o
);

  logic [DistW-1:0] dist_d, dist_q;

  always_comb begin
    dist_d = '0;
    for (int k = 0; k < NumWords; k++) begin
      dist_d = dist_d + DistW'(cnt_i[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      dist_q <= dist_d;
    end
  end

  assign dist_o = dist_q;

endmodule

FILE: rtl/hns_tracker.sv
// running minimum, position counter and result register
module hns_tracker import hns_pkg::*; #(
  parameter logic [IdxW-1:0] POS_LIMIT = 16'hFFFF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  trk_ctl_t         ctl_i,
  input  logic [DistW-1:0] dist_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [IdxW-1:0]  best_index_o,
  output logic [DistW-1:0] best_distance_o
);

  logic [DistW-1:0] min_d, min_q;
  logic [IdxW-1:0]  best_d, best_q;
  logic [IdxW-1:0]  pos_d, pos_q;
  logic             ov_d, ov_q;
  logic [DistW-1:0] new_min;
  logic [IdxW-1:0]  new_best;
  logic             load_out;
  logic [IdxW-1:0]  idx_q;
  logic [DistW-1:0] dst_q;

  // strictly nearer replaces, so ties keep the earlier position
  always_comb begin
    if (dist_i < min_q) begin
      new_min  = dist_i;
      new_best = pos_q;
    end else begin
      new_min  = min_q;
      new_best = best_q;
    end
  end

  assign load_out = ctl_i.upd && ctl_i.last;

  always_comb begin
    min_d  = min_q;
    best_d = best_q;
    pos_d  = pos_q;
    if (ctl_i.upd) begin
      if (ctl_i.last) begin
        min_d  = MinReset;
        best_d = '0;
        pos_d  = '0;
      end else begin
        min_d  = new_min;
        best_d = new_best;
        pos_d  = (pos_q < POS_LIMIT) ? pos_q + 1'b1 : pos_q;
      end
    end
  end

  always_comb begin
    ov_d = ov_q;
    if (load_out) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= MinReset;
      best_q <= '0;
      pos_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      min_q  <= min_d;
      best_q <= best_d;
      pos_q  <= pos_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      idx_q <= new_best;
      dst_q <= new_min;
    end
  end

  assign out_valid_o     = ov_q;
  assign best_index_o    = idx_q;
  assign best_distance_o = dst_q;

  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!ov_q || out_ready_i))
    else $error("result register overwritten");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (min_q == MinReset && pos_q == '0 && best_q == '0 && ov_q))
    else $error("running state not cleared after last vector");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_LIMIT)
    else $error("position counter past its limit");

  a_dist_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.upd |-> dist_i <= MaxDist)
    else $error("distance above 512");

endmodule

FILE: rtl/hamming_nearest_search_512.sv
// top level of the 512-bit hamming nearest search
// Streams 512-bit corpus vectors against a 512-bit query held in eight
// 64-bit registers and reports, on the vector marked final, the position and
// hamming distance of the nearest vector (the earliest one on a tie), then
// starts a new search; the query is kept. One vector is taken every cycle
// unless a final vector is held back. A vector goes through three register
// stages: eight lanes that each xor and popcount one 64-bit word, a merge
// register that sums the lane counts, and the running-minimum compare, which
// is the only stage that carries state from one vector to the next and loads
// the result register. A result is loaded when its final vector leaves the
// merge register. While a result waits to be taken, non-final vectors keep
// flowing; only a second final vector waits at the compare stage until the
// result register is free. Positions stop at the smaller of MAX_CORPUS-1 and
// 65535. Query registers take writes at indexes 0 to 7; other indexes are
// ignored. Write the query only while no search is in flight.
module hamming_nearest_search_512 import hns_pkg::*; #(
  parameter longint unsigned MAX_CORPUS = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  word_t              cfg_data_i,
  hns_in_if.sink             in_i,
  hns_out_if.source          out_o
);

  // last position the counter may reach
  localparam logic [IdxW-1:0] PosLimit =
    (MAX_CORPUS - 1 > 65535) ? 16'hFFFF : IdxW'(MAX_CORPUS - 1);

  // query registers
  word_t query_q [NumWords];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumWords; k++) begin
        query_q[k] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i < CfgIdxW'(NumWords))) begin
      query_q[cfg_idx_i[WordSelW-1:0]] <= cfg_data_i;
    end
  end

  // pipeline occupancy and the final flag that rides along
  logic s1_v_d, s1_v_q, s1_final_q;
  logic s2_v_d, s2_v_q, s2_final_q;
  logic in_xfer, s1_go, s1_free, s2_go, s2_free, out_free, out_valid;
  trk_ctl_t trk_ctl;

  // result register can take a new result this cycle
  assign out_free = !out_valid || out_o.ready;
  // a non-final vector never needs the result register
  assign s2_go    = s2_v_q && (!s2_final_q || out_free);
  assign s2_free  = !s2_v_q || s2_go;
  assign s1_go    = s1_v_q && s2_free;
  assign s1_free  = !s1_v_q || s1_go;

  assign in_i.ready = s1_free;
  assign in_xfer    = in_i.valid && s1_free;

  assign s1_v_d = s1_free ? in_xfer : s1_v_q;
  assign s2_v_d = s2_free ? s1_v_q  : s2_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_final_q <= in_i.final_vector;
    end
    if (s1_go) begin
      s2_final_q <= s1_final_q;
    end
  end

  // lanes: one 64-bit word each
  word_t            vec_w [NumWords];
  lane_cnt_t        lane_cnt [NumWords];
  logic [DistW-1:0] dist_sum;

  assign vec_w[0] = in_i.vec_word_0;
  assign vec_w[1] = in_i.vec_word_1;
  assign vec_w[2] = in_i.vec_word_2;
  assign vec_w[3] = in_i.vec_word_3;
  assign vec_w[4] = in_i.vec_word_4;
  assign vec_w[5] = in_i.vec_word_5;
  assign vec_w[6] = in_i.vec_word_6;
  assign vec_w[7] = in_i.vec_word_7;

  for (genvar g = 0; g < NumWords; g++) begin : g_lane
    hns_lane u_lane (
      .clk_i   (clk_i),
      .load_i  (in_xfer),
      .vec_i   (vec_w[g]),
      .query_i (query_q[g]),
      .cnt_o   (lane_cnt[g])
    );
  end

  hns_merge u_merge (
    .clk_i  (clk_i),
    .load_i (s1_go),
    .cnt_i  (lane_cnt),
    .dist_o (dist_sum)
  );

  assign trk_ctl = '{upd: s2_go, last: s2_final_q};

  hns_tracker #(
    .POS_LIMIT (PosLimit)
  ) u_tracker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (trk_ctl),
    .dist_i          (dist_sum),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_valid),
    .best_index_o    (out_o.best_index),
    .best_distance_o (out_o.best_distance)
  );

  assign out_o.valid = out_valid;

endmodule
